>>> rtl/core/rtw_pkg.sv
// ---------------------------------------------------------------------------
// Row warp package
// Shared widths, register indexes, controller state codes and command bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package rtw_pkg;

  localparam int unsigned MaxWidthDef = 64;
  localparam int unsigned WidthW      = 7;
  localparam int unsigned HeightW     = 12;
  localparam int unsigned PixW        = 24;
  localparam int unsigned CfgIdxW     = 2;
  // sums: up to 64 pixels of 255
  localparam int unsigned SumW        = 14;

  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegKey    = 2'd2;

  typedef enum logic [3:0] {
    StLoad,
    StSpanDiv,
    StSpanMul,
    StColSetup,
    StLoDiv,
    StHiDiv,
    StAccum,
    StAvgDiv,
    StEmit
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // store accepted pixel, advance column
    logic span_start; // start row span computation
    logic col_first;  // reset column counter for emission
    logic col_setup;  // compute per-column bounds numerators
    logic lo_start;   // start lo boundary divide
    logic hi_start;   // start hi boundary divide
    logic acc_clear;  // clear accumulators, set k to lo
    logic acc_step;   // accumulate one source column
    logic avg_start;  // start channel divides
    logic emit;       // drive result
    logic col_next;   // advance column
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_done;   // pixel just loaded completes the row
    logic div_done;   // divider finished
    logic in_span;    // current column lies inside the kept span
    logic acc_done;   // k reached hi
    logic last_col;   // current column is the last one
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/rtw_div.sv
// ---------------------------------------------------------------------------
// Row warp divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rtw_div #(
  parameter int unsigned NumW = 19,
  parameter int unsigned DenW = 12
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  // one restoring step per cycle
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/rtw_ctrl.sv
// ---------------------------------------------------------------------------
// Row warp controller
// Sequences row load, span setup, per-column averaging and emission.
// ---------------------------------------------------------------------------
`default_nettype none

module rtw_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire rtw_pkg::stat_t stat_i,
  output rtw_pkg::cmd_t       cmd_o,
  output logic                busy_o
);

  import rtw_pkg::*;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StLoad:     if (start_i && stat_i.row_done) state_d = StSpanDiv;
      StSpanDiv:  if (stat_i.div_done) state_d = StSpanMul;
      StSpanMul:  state_d = StColSetup;
      StColSetup: state_d = stat_i.in_span ? StLoDiv : StEmit;
      StLoDiv:    if (stat_i.div_done) state_d = StHiDiv;
      StHiDiv:    if (stat_i.div_done) state_d = StAccum;
      StAccum:    if (stat_i.acc_done) state_d = StAvgDiv;
      StAvgDiv:   if (stat_i.div_done) state_d = StEmit;
      StEmit:     state_d = stat_i.last_col ? StLoad : StColSetup;
      default:    state_d = StLoad;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      StLoad: begin
        busy_o          = 1'b0;
        cmd_o.load      = start_i;
        cmd_o.span_start = start_i && stat_i.row_done;
      end
      StSpanDiv:  cmd_o.col_first = stat_i.div_done;
      StSpanMul:  ;
      StColSetup: begin
        cmd_o.col_setup = 1'b1;
        cmd_o.lo_start  = stat_i.in_span;
      end
      StLoDiv: begin
        cmd_o.hi_start = stat_i.div_done;
      end
      StHiDiv: cmd_o.acc_clear = stat_i.div_done;
      StAccum: begin
        cmd_o.acc_step  = !stat_i.acc_done;
        cmd_o.avg_start = stat_i.acc_done;
      end
      StAvgDiv: ;
      StEmit: begin
        cmd_o.emit     = 1'b1;
        cmd_o.col_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rtw_dp.sv
// ---------------------------------------------------------------------------
// Row warp datapath
// Row memory, counters, span bounds, accumulators and shared divider.
// ---------------------------------------------------------------------------
`default_nettype none

module rtw_dp #(
  parameter int unsigned MaxWidth = rtw_pkg::MaxWidthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rtw_pkg::cmd_t                 cmd_i,
  output rtw_pkg::stat_t                     stat_o,
  input  wire logic [7:0]                    pixel_red_i,
  input  wire logic [7:0]                    pixel_green_i,
  input  wire logic [7:0]                    pixel_blue_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [rtw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i,
  output logic                               res_valid_o,
  output logic [7:0]                         out_red_o,
  output logic [7:0]                         out_green_o,
  output logic [7:0]                         out_blue_o,
  output logic                               row_end_o,
  output logic                               frame_end_o
);

  import rtw_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam int unsigned NumW  = HeightW + WidthW;

  // configuration
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [PixW-1:0]    key_q;
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;

  always_comb begin
    if (width_q == '0) w_eff = WidthW'(1);
    else if (width_q > WidthW'(MaxWidth)) w_eff = WidthW'(MaxWidth);
    else w_eff = width_q;
    h_eff = (height_q == '0) ? HeightW'(1) : height_q;
  end

  logic [WidthW-1:0]  colc_q;
  logic [HeightW-1:0] rowc_q;
  logic [WidthW-1:0]  colc_wr;
  logic [HeightW-1:0] rowc_cur;
  logic               row_last;

  assign colc_wr  = (colc_q >= w_eff) ? '0 : colc_q;
  assign rowc_cur = (rowc_q >= h_eff) ? '0 : rowc_q;
  assign row_last = ({1'b0, rowc_cur} + 1'b1) >= {1'b0, h_eff};

  // row memory
  logic [PixW-1:0]  mem [MaxWidth];
  logic [PixW-1:0]  rd_q;
  logic [AddrW-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem[colc_wr[AddrW-1:0]] <= {pixel_blue_i, pixel_green_i, pixel_red_i};
    rd_q <= mem[rd_addr];
  end

  // per-row and per-column registers
  logic [WidthW-1:0] da1_q, da2_q, dx1, dx2;
  logic [WidthW-1:0] c_q, den_q;
  logic              mir_q;
  logic [WidthW-1:0] lo_q, hi_q, k_q;
  logic              rd_vld_q;
  logic [SumW-1:0]   sr_q, sg_q, sb_q;
  logic [WidthW-1:0] n_q;
  logic [1:0]        ch_q;
  logic [7:0]        ar_q, ag_q;
  logic [12:0]       bnum_q;
  logic              in_span;

  assign dx1 = w_eff >> 1;
  assign dx2 = w_eff - dx1;

  // column bounds for column c
  logic [WidthW-1:0] xs;
  logic              right;
  assign right = (c_q >= dx1);
  assign xs    = right ? (c_q - dx1) : (dx1 - 1'b1 - c_q);
  assign in_span = right ? (xs < da2_q) : (xs < da1_q);

  // shared divider
  logic              div_start, div_done;
  logic [NumW-1:0]   div_num, div_quo;
  logic [HeightW-1:0] div_den;
  logic [1:0]        phase_q; // 0 span,1 lo,2 hi,3 avg

  rtw_div #(.NumW(NumW), .DenW(HeightW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [12:0] prod_lo, prod_hi, mul_w;
  assign mul_w   = right ? 13'(dx2) : 13'(dx1);
  assign prod_lo = 13'(xs) * mul_w;
  assign prod_hi = 13'({1'b0, xs} + 8'd1) * mul_w;

  // sum for the channel after the one just divided
  logic [SumW-1:0] ch_sum;
  always_comb begin
    case (ch_q)
      2'd0:    ch_sum = sg_q;
      default: ch_sum = sb_q;
    endcase
  end

  logic avg_next;
  assign avg_next = (phase_q == 2'd3) && div_done && (ch_q != 2'd2);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = HeightW'(1);
    if (cmd_i.span_start) begin
      div_start = 1'b1;
      div_num   = NumW'(rowc_cur) * NumW'(w_eff);
      div_den   = h_eff - 1'b1;
    end else if (cmd_i.lo_start) begin
      div_start = 1'b1;
      div_num   = NumW'(prod_lo);
      div_den   = HeightW'(right ? da2_q : da1_q);
    end else if (cmd_i.hi_start) begin
      div_start = 1'b1;
      div_num   = NumW'(bnum_q);
      div_den   = HeightW'(den_q);
    end else if (cmd_i.avg_start || avg_next) begin
      div_start = n_q != '0;
      div_num   = NumW'(cmd_i.avg_start ? sr_q : ch_sum);
      div_den   = HeightW'(n_q);
    end
  end

  // memory read address: source column for k
  logic [WidthW-1:0] src_col;
  assign src_col = mir_q ? (dx1 - k_q - 1'b1) : (dx1 + k_q);
  assign rd_addr = src_col[AddrW-1:0];

  // source columns left to read
  logic acc_more;
  assign acc_more = (k_q < hi_q);

  logic emit_key;
  logic avg_fin;
  assign avg_fin = (phase_q == 2'd3) && div_done && (ch_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(64);
      height_q <= HeightW'(64);
      key_q    <= '0;
      colc_q   <= '0;
      rowc_q   <= '0;
      phase_q  <= '0;
      ch_q     <= '0;
      rd_vld_q <= 1'b0;
      res_valid_o <= 1'b0;
      emit_key <= 1'b0;
    end else begin
      res_valid_o <= cmd_i.emit;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegWidth:  begin width_q  <= cfg_data_i[WidthW-1:0];  colc_q <= '0; rowc_q <= '0; end
          RegHeight: begin height_q <= cfg_data_i[HeightW-1:0]; colc_q <= '0; rowc_q <= '0; end
          RegKey:    key_q <= cfg_data_i[PixW-1:0];
          default:   ;
        endcase
      end
      if (cmd_i.load) begin
        rowc_q <= rowc_cur;
        if (colc_wr + 1'b1 >= w_eff) colc_q <= '0;
        else colc_q <= colc_wr + 1'b1;
      end
      if (cmd_i.span_start) phase_q <= 2'd0;
      if (cmd_i.lo_start) phase_q <= 2'd1;
      if (cmd_i.hi_start) phase_q <= 2'd2;
      if (cmd_i.avg_start) begin
        phase_q  <= 2'd3;
        ch_q     <= 2'd0;
        emit_key <= (n_q == '0);
      end
      if (cmd_i.col_setup) emit_key <= !in_span;
      if (avg_next) ch_q <= ch_q + 1'b1;
      rd_vld_q <= cmd_i.acc_step && acc_more;
      if (cmd_i.col_next && row_last && stat_o.last_col) rowc_q <= '0;
      else if (cmd_i.col_next && stat_o.last_col) rowc_q <= rowc_cur + 1'b1;
    end
  end

  // bounds, accumulators, results
  always_ff @(posedge clk_i) begin
    if (cmd_i.col_first) begin
      c_q <= '0;
      if (h_eff == HeightW'(1)) begin
        da1_q <= w_eff >> 1;
        da2_q <= w_eff - (w_eff >> 1);
      end else begin
        da1_q <= div_quo[WidthW-1:0] >> 1;
        da2_q <= div_quo[WidthW-1:0] - (div_quo[WidthW-1:0] >> 1);
      end
    end
    if (cmd_i.col_setup) begin
      mir_q <= !right;
      den_q <= right ? da2_q : da1_q;
      bnum_q <= prod_hi;
    end
    if (phase_q == 2'd1 && div_done) lo_q <= div_quo[WidthW-1:0];
    if (phase_q == 2'd2 && div_done) hi_q <= div_quo[WidthW-1:0];
    if (cmd_i.acc_clear) begin
      k_q  <= lo_q;
      sr_q <= '0;
      sg_q <= '0;
      sb_q <= '0;
      n_q  <= '0;
    end else if (cmd_i.acc_step && acc_more) begin
      k_q <= k_q + 1'b1;
    end
    if (rd_vld_q && rd_q != key_q) begin
      sr_q <= sr_q + SumW'(rd_q[7:0]);
      sg_q <= sg_q + SumW'(rd_q[15:8]);
      sb_q <= sb_q + SumW'(rd_q[23:16]);
      n_q  <= n_q + 1'b1;
    end
    if (phase_q == 2'd3 && div_done) begin
      if (ch_q == 2'd0) ar_q <= div_quo[7:0];
      if (ch_q == 2'd1) ag_q <= div_quo[7:0];
    end
    if (avg_fin) begin
      out_red_o   <= ar_q;
      out_green_o <= ag_q;
      out_blue_o  <= div_quo[7:0];
    end
    if (cmd_i.emit) begin
      if (emit_key) begin
        out_red_o   <= key_q[7:0];
        out_green_o <= key_q[15:8];
        out_blue_o  <= key_q[23:16];
      end
      row_end_o   <= stat_o.last_col;
      frame_end_o <= stat_o.last_col && row_last;
    end
    if (cmd_i.col_next) c_q <= c_q + 1'b1;
  end

  // span is done once k reached hi and the last read has been summed
  logic acc_end;
  assign acc_end = (k_q >= hi_q) && !rd_vld_q;

  always_comb begin
    stat_o          = '0;
    stat_o.row_done = (colc_wr + 1'b1) >= w_eff;
    stat_o.div_done = (div_done && !avg_next) ||
                      ((phase_q == 2'd3) && emit_key && ch_q == 2'd0 && n_q == '0);
    stat_o.in_span  = in_span;
    stat_o.acc_done = acc_end;
    stat_o.last_col = (c_q + 1'b1) == w_eff;
  end

endmodule

`default_nettype wire

>>> rtl/core/rect_to_triangle_row_warp.sv
// ---------------------------------------------------------------------------
// Rectangle to triangle row warp
// Stores one row of pixels, then emits it squeezed into a centered triangle.
// ---------------------------------------------------------------------------
// Loading takes one pixel per cycle while start is high; busy stays low
// while a row fills. On the last pixel of a row the block goes busy and
// emits one result per column of the configured width on result_valid_o,
// one column at a time; the receiver cannot stall. A kept column runs a
// setup step, two bound divides on the shared 19-bit serial divider, the
// accumulation of its source pixels, three channel divides and an emit
// step. A kept column whose source pixels all match the key skips the
// channel divides. Columns outside the span go from setup straight to emit.
// busy drops in the cycle that carries the last result of the row.
`default_nettype none

module rect_to_triangle_row_warp #(
  parameter int unsigned MaxWidth = rtw_pkg::MaxWidthDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [7:0]                  pixel_red_i,
  input  wire logic [7:0]                  pixel_green_i,
  input  wire logic [7:0]                  pixel_blue_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rtw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                 cfg_data_i,
  output logic                             result_valid_o,
  output logic [7:0]                       out_red_o,
  output logic [7:0]                       out_green_o,
  output logic [7:0]                       out_blue_o,
  output logic                             row_end_o,
  output logic                             frame_end_o
);

  import rtw_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy_c;

  assign cfg_ready_o = 1'b1;
  assign busy        = busy_c;

  rtw_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start && !busy_c),
    .stat_i(stat), .cmd_o(cmd), .busy_o(busy_c)
  );

  rtw_dp #(.MaxWidth(MaxWidth)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat),
    .pixel_red_i, .pixel_green_i, .pixel_blue_i,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .res_valid_o(result_valid_o),
    .out_red_o, .out_green_o, .out_blue_o, .row_end_o, .frame_end_o
  );

endmodule

`default_nettype wire

>>> rtl/core/rtw_checker.sv
// ---------------------------------------------------------------------------
// Row warp checker
// Port-level properties of the warp block.
// ---------------------------------------------------------------------------
`default_nettype none

module rtw_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_o,
  input wire logic row_end_o,
  input wire logic frame_end_o
);

  // frame end only closes a row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && frame_end_o |-> row_end_o) else $error("frame_end without row_end");

  // results only appear while busy or right after
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy || $past(busy)) else $error("result while idle");

  // a row end releases the block
  a_row_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && row_end_o |-> !busy) else $error("busy after row end");

endmodule

bind rect_to_triangle_row_warp rtw_checker u_chk (.*);

`default_nettype wire
